/* hw/rtl/edit_distance_top_macros.svh */
// ----------------------------------------------------------------------------
// edit_distance_top_macros.svh
// Assertion macros for the edit distance block. Empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef EDIT_DISTANCE_TOP_MACROS_SVH
`define EDIT_DISTANCE_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define ED_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("edit_distance assertion failed");
// next-cycle implication, checked out of reset
`define ED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("edit_distance assertion failed");
`else
`define ED_ASSERT_IMP(label, ante, cons)
`define ED_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* hw/rtl/ed_pkg.sv */
// ----------------------------------------------------------------------------
// ed_pkg
// Shared constants and word types of the edit distance block.
// ----------------------------------------------------------------------------
package ed_pkg;

    // default sizing
    localparam int MAX_LEN     = 64;
    localparam int SYMBOL_BITS = 8;

    // fixed field widths
    localparam int ACTION_W   = 2;
    localparam int SYMBOL_W   = 8;
    localparam int DISTANCE_W = 7;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_SOURCE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TARGET  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;

    // input word
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SYMBOL_W-1:0] symbol;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [DISTANCE_W-1:0] distance;
        logic                  overflow;
    } t_out_word;

    // top -> sweep control
    typedef struct packed {
        logic start;
        logic ack;
    } t_sweep_ctl;

    // sweep -> top status
    typedef struct packed {
        logic done;
        logic src_rd;
        logic tgt_rd;
    } t_sweep_sts;

endpackage

/* hw/rtl/ed_sweep.sv */
// ----------------------------------------------------------------------------
// ed_sweep
// Distance sequencer: owns the cost row memory and sweeps it once per
// source symbol, one cell per cycle, reading the symbol stores of the top.
// ----------------------------------------------------------------------------
module ed_sweep #(
    parameter int MAX_LEN = ed_pkg::MAX_LEN,
    parameter int SYM_W   = ed_pkg::SYMBOL_BITS,
    localparam int LW     = $clog2(MAX_LEN + 1),
    localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ed_pkg::t_sweep_ctl i_ctl,
    input  logic [LW-1:0]      i_src_len,
    input  logic [LW-1:0]      i_tgt_len,
    output ed_pkg::t_sweep_sts o_sts,
    output logic [AW-1:0]      o_src_addr,
    output logic [AW-1:0]      o_tgt_addr,
    input  logic [SYM_W-1:0]   i_src_sym,
    input  logic [SYM_W-1:0]   i_tgt_sym,
    output logic [LW-1:0]      o_result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_ROW  = 3'd2;
    localparam logic [2:0] S_CELL = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [LW-1:0] r_n, n_n;
    logic [LW-1:0] r_m, n_m;
    logic [LW-1:0] r_i, n_i;
    logic [LW-1:0] r_j, n_j;
    logic [LW-1:0] r_diag, n_diag;
    logic [LW-1:0] r_left, n_left;
    logic [LW-1:0] r_result, n_result;

    // cost row memory
    logic [LW-1:0] r_row [MAX_LEN+1];
    logic [LW-1:0] r_row_q;
    logic          w_row_we;
    logic [LW-1:0] w_row_waddr;
    logic [LW-1:0] w_row_wdata;
    logic          w_row_re;
    logic [LW-1:0] w_row_raddr;

    // cell arithmetic, one bit wider for the +1
    logic [LW:0]   w_sub;
    logic [LW:0]   w_del;
    logic [LW:0]   w_ins;
    logic [LW:0]   w_min1;
    logic [LW:0]   w_best;

    always_comb begin
        w_sub  = {1'b0, r_diag} + {{LW{1'b0}}, (i_src_sym != i_tgt_sym)};
        w_del  = {1'b0, r_row_q} + {{LW{1'b0}}, 1'b1};
        w_ins  = {1'b0, r_left} + {{LW{1'b0}}, 1'b1};
        w_min1 = (w_sub < w_del) ? w_sub : w_del;
        w_best = (w_min1 < w_ins) ? w_min1 : w_ins;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_m         = r_m;
        n_i         = r_i;
        n_j         = r_j;
        n_diag      = r_diag;
        n_left      = r_left;
        n_result    = r_result;
        w_row_we    = 1'b0;
        w_row_waddr = r_j;
        w_row_wdata = r_j;
        w_row_re    = 1'b0;
        w_row_raddr = r_j + LW'(1);
        o_sts       = '0;
        o_src_addr  = AW'(r_i - LW'(1));
        o_tgt_addr  = r_j[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_n = i_src_len;
                    n_m = i_tgt_len;
                    n_j = '0;
                    if (i_src_len == '0) begin
                        n_result = i_tgt_len;
                        n_state  = S_DONE;
                    end else if (i_tgt_len == '0) begin
                        n_result = i_src_len;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                // row zero: cost of j insertions
                w_row_we = 1'b1;
                if (r_j == r_m) begin
                    n_i     = LW'(1);
                    n_state = S_ROW;
                end else begin
                    n_j = r_j + LW'(1);
                end
            end
            S_ROW: begin
                // new left edge, fetch source symbol and first column
                w_row_we    = 1'b1;
                w_row_waddr = '0;
                w_row_wdata = r_i;
                w_row_re    = 1'b1;
                w_row_raddr = LW'(1);
                o_sts.src_rd = 1'b1;
                o_sts.tgt_rd = 1'b1;
                o_tgt_addr  = '0;
                n_diag      = r_i - LW'(1);
                n_left      = r_i;
                n_j         = LW'(1);
                n_state     = S_CELL;
            end
            S_CELL: begin
                // write column j, read column j+1 (never the same entry)
                w_row_we    = 1'b1;
                w_row_wdata = w_best[LW-1:0];
                n_left      = w_best[LW-1:0];
                n_diag      = r_row_q;
                if (r_j != r_m) begin
                    w_row_re     = 1'b1;
                    o_sts.tgt_rd = 1'b1;
                    n_j          = r_j + LW'(1);
                end else if (r_i == r_n) begin
                    n_result = w_best[LW-1:0];
                    n_state  = S_DONE;
                end else begin
                    n_i     = r_i + LW'(1);
                    n_state = S_ROW;
                end
            end
            S_DONE: begin
                o_sts.done = 1'b1;
                if (i_ctl.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_m      <= n_m;
        r_i      <= n_i;
        r_j      <= n_j;
        r_diag   <= n_diag;
        r_left   <= n_left;
        r_result <= n_result;
    end

    // cost row memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_row_we) begin
            r_row[w_row_waddr] <= w_row_wdata;
        end
        if (w_row_re) begin
            r_row_q <= r_row[w_row_raddr];
        end
    end

    assign o_result = r_result;

endmodule

/* hw/rtl/edit_distance_top.sv */
// ----------------------------------------------------------------------------
// edit_distance_top
// Levenshtein distance between two symbol strings with unit edit costs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word): each word appends
//   one symbol to the source or target string, or asks for the distance.
//   Appends are taken one per cycle while not stalled and give no output
//   word; symbols past MAX_LEN are dropped and flag overflow. An unused
//   action is taken and ignored.
//   A compute word returns one output word (distance, overflow) and empties
//   both strings. For lengths n and m, both nonzero, the sweep writes
//   row zero, then starts one row per source symbol and fills it one cell
//   per cycle, bounded by the single port pair of the cost row memory.
//   With an empty string the sweep goes straight to its done state.
//   The input is stalled for the whole sweep, until the result is in the
//   output register.
//   Output channel (o_out_valid / i_out_stall / o_out_word): a result holds
//   in the output register while stalled; appends are still taken then.
//   Reset (i_rst_n low, synchronous) empties both strings, clears overflow
//   and drops any pending result. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "edit_distance_top_macros.svh"

module edit_distance_top #(
    parameter int MAX_LEN     = ed_pkg::MAX_LEN,
    parameter int SYMBOL_BITS = ed_pkg::SYMBOL_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ed_pkg::t_in_word i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ed_pkg::t_out_word o_out_word
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SW = (SYMBOL_BITS < ed_pkg::SYMBOL_W) ? SYMBOL_BITS : ed_pkg::SYMBOL_W;
    localparam int DW = ed_pkg::DISTANCE_W;

    logic [LW-1:0] r_src_len;
    logic [LW-1:0] r_tgt_len;
    logic          r_dropped;
    logic          r_busy;
    logic          r_ovf_hold;
    logic          r_out_valid;
    ed_pkg::t_out_word r_out;

    logic              w_in_take;
    logic              w_ack;
    logic              w_src_full;
    logic              w_tgt_full;
    logic [SW-1:0]     w_sym;
    ed_pkg::t_sweep_ctl w_ctl;
    ed_pkg::t_sweep_sts w_sts;
    logic [AW-1:0]     w_src_raddr;
    logic [AW-1:0]     w_tgt_raddr;
    logic [LW-1:0]     w_result;
    logic [LW+DW-1:0]  w_dist_ext;

    // symbol stores
    logic [SW-1:0] r_src_mem [MAX_LEN];
    logic [SW-1:0] r_tgt_mem [MAX_LEN];
    logic [SW-1:0] r_src_q;
    logic [SW-1:0] r_tgt_q;

    // handshake
    assign o_in_stall = r_busy;
    assign w_in_take  = i_in_valid && !r_busy;
    assign w_ack      = w_sts.done && (!r_out_valid || !i_out_stall);
    assign w_src_full = (r_src_len == LW'(MAX_LEN));
    assign w_tgt_full = (r_tgt_len == LW'(MAX_LEN));
    assign w_sym      = i_in_word.symbol[SW-1:0];

    always_comb begin
        w_ctl       = '0;
        w_ctl.start = w_in_take && (i_in_word.action == ed_pkg::ACT_COMPUTE);
        w_ctl.ack   = w_ack;
    end

    // lengths, overflow flag and busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_len <= '0;
            r_tgt_len <= '0;
            r_dropped <= 1'b0;
            r_busy    <= 1'b0;
        end else begin
            if (w_ack) begin
                r_busy <= 1'b0;
            end
            if (w_in_take) begin
                case (i_in_word.action)
                    ed_pkg::ACT_SOURCE: begin
                        if (w_src_full) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_src_len <= r_src_len + LW'(1);
                        end
                    end
                    ed_pkg::ACT_TARGET: begin
                        if (w_tgt_full) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_tgt_len <= r_tgt_len + LW'(1);
                        end
                    end
                    ed_pkg::ACT_COMPUTE: begin
                        r_src_len <= '0;
                        r_tgt_len <= '0;
                        r_dropped <= 1'b0;
                        r_busy    <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // overflow travels with the pending compute
    always_ff @(posedge i_clk) begin
        if (w_ctl.start) begin
            r_ovf_hold <= r_dropped;
        end
    end

    // symbol store writes and sweep reads
    always_ff @(posedge i_clk) begin
        if (w_in_take && (i_in_word.action == ed_pkg::ACT_SOURCE) && !w_src_full) begin
            r_src_mem[r_src_len[AW-1:0]] <= w_sym;
        end
        if (w_in_take && (i_in_word.action == ed_pkg::ACT_TARGET) && !w_tgt_full) begin
            r_tgt_mem[r_tgt_len[AW-1:0]] <= w_sym;
        end
        if (w_sts.src_rd) begin
            r_src_q <= r_src_mem[w_src_raddr];
        end
        if (w_sts.tgt_rd) begin
            r_tgt_q <= r_tgt_mem[w_tgt_raddr];
        end
    end

    ed_sweep #(
        .MAX_LEN (MAX_LEN),
        .SYM_W   (SW)
    ) u_sweep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_src_len  (r_src_len),
        .i_tgt_len  (r_tgt_len),
        .o_sts      (w_sts),
        .o_src_addr (w_src_raddr),
        .o_tgt_addr (w_tgt_raddr),
        .i_src_sym  (r_src_q),
        .i_tgt_sym  (r_tgt_q),
        .o_result   (w_result)
    );

    // output register
    assign w_dist_ext = {{DW{1'b0}}, w_result};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ack) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out.distance <= w_dist_ext[DW-1:0];
            r_out.overflow <= r_ovf_hold;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // checks
    `ED_ASSERT_IMP(a_done_busy, w_sts.done, r_busy)
    `ED_ASSERT_NEXT(a_ack_loads, w_ack, o_out_valid && !w_sts.done && !o_in_stall)
    `ED_ASSERT_NEXT(a_compute_clears, w_ctl.start, ~|{r_src_len, r_tgt_len, r_dropped})
    `ED_ASSERT_IMP(a_len_bound, 1'b1, (r_src_len <= LW'(MAX_LEN)) && (r_tgt_len <= LW'(MAX_LEN)))

endmodule
